// ===== sv/vmr_pkg.sv =====
package vmr_pkg;

    // Sizing
    localparam int NUM_QUEUES     = 4;
    localparam int QUEUE_SIZE_MAX = 256;
    localparam int CONFIG_WORDS   = 64;
    localparam int Q_AW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CFG_AW = (CONFIG_WORDS > 1) ? $clog2(CONFIG_WORDS) : 1;

    // Fixed register values
    localparam logic [31:0] MAGIC_WORD = 32'h7472_6976;
    localparam logic [31:0] VERSION    = 32'd2;
    localparam logic [31:0] CFG_START  = 32'h0000_0100;

    // Register offsets within the window
    localparam logic [7:0] OFF_MAGIC      = 8'h00;
    localparam logic [7:0] OFF_VERSION    = 8'h04;
    localparam logic [7:0] OFF_DEVICE_ID  = 8'h08;
    localparam logic [7:0] OFF_VENDOR_ID  = 8'h0c;
    localparam logic [7:0] OFF_FEATURES   = 8'h10;
    localparam logic [7:0] OFF_FEAT_SEL   = 8'h14;
    localparam logic [7:0] OFF_QUEUE_SEL  = 8'h30;
    localparam logic [7:0] OFF_QUEUE_MAX  = 8'h34;
    localparam logic [7:0] OFF_QUEUE_NUM  = 8'h38;
    localparam logic [7:0] OFF_QUEUE_RDY  = 8'h44;
    localparam logic [7:0] OFF_NOTIFY     = 8'h50;
    localparam logic [7:0] OFF_INT_STATUS = 8'h60;
    localparam logic [7:0] OFF_INT_ACK    = 8'h64;
    localparam logic [7:0] OFF_STATUS     = 8'h70;
    localparam logic [7:0] OFF_DESC_LO    = 8'h80;
    localparam logic [7:0] OFF_DESC_HI    = 8'h84;
    localparam logic [7:0] OFF_AVAIL_LO   = 8'h90;
    localparam logic [7:0] OFF_AVAIL_HI   = 8'h94;
    localparam logic [7:0] OFF_USED_LO    = 8'ha0;
    localparam logic [7:0] OFF_USED_HI    = 8'ha4;
    localparam logic [7:0] OFF_GENERATION = 8'hfc;

    // Access kinds
    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_CFG_READ = 2'd2,
        OP_EVENT    = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE     = 2'd0,
        CFG_DEVICE   = 2'd1,
        CFG_VENDOR   = 2'd2,
        CFG_FEAT_LOW = 2'd3
    } t_cfg_idx;

    // One queue's entry in the queue memory
    typedef struct packed {
        logic        ready;
        logic [15:0] size;
        logic [63:0] desc;
        logic [63:0] avail;
        logic [63:0] used;
    } t_qent;

endpackage

// ===== sv/vmr_req_if.sv =====
interface vmr_req_if
    import vmr_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] bus_address;
    logic [31:0] write_data;

    modport source (output valid, op, bus_address, write_data, input ready);
    modport sink   (input valid, op, bus_address, write_data, output ready);
endinterface

// ===== sv/vmr_rsp_if.sv =====
interface vmr_rsp_if
    import vmr_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        handled;
    logic        irq_level;
    logic        notify_valid;
    logic [1:0]  notify_queue;

    modport source (output valid, read_data, handled, irq_level, notify_valid, notify_queue,
                    input ready);
    modport sink   (input valid, read_data, handled, irq_level, notify_valid, notify_queue,
                    output ready);
endinterface

// ===== sv/vmr_cfg_if.sv =====
interface vmr_cfg_if
    import vmr_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/virtio_mmio_register_file.sv =====
// Channel   Dir  Payload                                             Transfer
// i_req     in   op, bus_address, write_data                         valid & ready
// o_rsp     out  read_data, handled, irq_level, notify_valid/queue   valid & ready
// i_cfg     in   index, data (base, device id, vendor id, features)  valid & ready
//
// On transfer, an access issues the reads of the config memory and the queue
// memory; once the registered read data is out, it decodes, writes back and loads
// the result register. i_req is held off while an access is in flight, so a new
// access is taken only after the one in flight has completed.
// Synchronous active-low reset clears all control state and the entry valid
// bits; no clearing pass is needed. A stalled o_rsp holds the result and the
// access behind it waits in its decode step until the result register frees.
module virtio_mmio_register_file
    import vmr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vmr_req_if.sink   i_req,
    vmr_rsp_if.source o_rsp,
    vmr_cfg_if.sink   i_cfg
);
    localparam int QW = $bits(t_qent);

    // Configuration registers
    logic [31:0] r_base, r_device, r_vendor, r_feat_low;

    // Transport state
    logic [31:0] r_status, r_queue_sel, r_feat_sel, r_int_bits;
    logic [31:0] n_status, n_queue_sel, n_feat_sel, n_int_bits;
    logic        r_irq, n_irq;
    logic [NUM_QUEUES-1:0]   r_q_vld;
    logic [CONFIG_WORDS-1:0] r_cfg_vld;
    logic [31:0] r_notify_cnt [NUM_QUEUES];

    // Access in flight
    logic        r_busy;
    logic [1:0]  r_op;
    logic [31:0] r_off, r_data;
    logic        r_cfg_hit;
    logic [CFG_AW-1:0] r_cfg_idx;

    // Result register
    logic        r_out_vld;
    logic [31:0] r_rd_data, n_rd_data;
    logic        r_handled, n_handled;
    logic        r_irq_lvl;
    logic        r_ntf_vld, n_ntf_vld;
    logic [1:0]  r_ntf_q, n_ntf_q;

    logic        accept, complete;
    logic [31:0] in_off, in_rel;
    logic        in_cfg_hit;
    logic [CFG_AW-1:0] in_cfg_idx;

    logic [31:0] cfg_rdata, cfg_word;
    logic        cfg_we;
    logic [QW-1:0] q_rdata_raw;
    t_qent       q_cur, q_new;
    logic        q_we, qok, clear_all, ntf_inc;
    logic [Q_AW-1:0] qi;
    logic [31:0] d;

    assign accept   = i_req.valid && i_req.ready;
    assign complete = r_busy && (!r_out_vld || o_rsp.ready);

    assign i_req.ready = !r_busy;
    assign i_cfg.ready = 1'b1;

    // Offset and config window decode at transfer
    assign in_off     = i_req.bus_address - r_base;
    assign in_rel     = in_off - CFG_START;
    assign in_cfg_hit = (in_off >= CFG_START) && (in_rel[31:2] < 30'(CONFIG_WORDS));
    assign in_cfg_idx = in_rel[CFG_AW+1:2];

    vmr_ram #(.WIDTH(32), .DEPTH(CONFIG_WORDS)) u_cfg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cfg_we),
        .i_wr_addr (r_cfg_idx),
        .i_wr_data (r_data),
        .i_rd_en   (accept),
        .i_rd_addr (in_cfg_idx),
        .o_rd_data (cfg_rdata)
    );

    vmr_ram #(.WIDTH(QW), .DEPTH(NUM_QUEUES)) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_we),
        .i_wr_addr (qi),
        .i_wr_data (q_new),
        .i_rd_en   (accept),
        .i_rd_addr (r_queue_sel[Q_AW-1:0]),
        .o_rd_data (q_rdata_raw)
    );

    // Decode step: entries never written since reset or clear read as zero
    assign qi       = r_queue_sel[Q_AW-1:0];
    assign qok      = r_queue_sel < 32'(NUM_QUEUES);
    assign q_cur    = (qok && r_q_vld[qi]) ? t_qent'(q_rdata_raw) : '0;
    assign cfg_word = (r_cfg_hit && r_cfg_vld[r_cfg_idx]) ? cfg_rdata : '0;
    assign d        = r_data;

    // Decode, modify and write back
    always_comb begin
        n_status    = r_status;
        n_queue_sel = r_queue_sel;
        n_feat_sel  = r_feat_sel;
        n_int_bits  = r_int_bits;
        n_irq       = r_irq;
        n_rd_data   = '0;
        n_handled   = 1'b0;
        n_ntf_vld   = 1'b0;
        n_ntf_q     = '0;
        q_new       = q_cur;
        q_we        = 1'b0;
        cfg_we      = 1'b0;
        clear_all   = 1'b0;
        ntf_inc     = 1'b0;
        case (t_op'(r_op))
            OP_READ: begin
                if (r_off >= CFG_START) begin
                    n_rd_data = cfg_word;
                    n_handled = r_cfg_hit;
                end else begin
                    n_handled = 1'b1;
                    unique case (r_off[7:0])
                        OFF_MAGIC:      n_rd_data = MAGIC_WORD;
                        OFF_VERSION:    n_rd_data = VERSION;
                        OFF_DEVICE_ID:  n_rd_data = r_device;
                        OFF_VENDOR_ID:  n_rd_data = r_vendor;
                        OFF_FEATURES: begin
                            if (r_feat_sel == '0) begin
                                n_rd_data = r_feat_low;
                            end else if (r_feat_sel == 32'd1) begin
                                n_rd_data = 32'd1;
                            end
                        end
                        OFF_FEAT_SEL:   n_rd_data = r_feat_sel;
                        OFF_QUEUE_SEL:  n_rd_data = r_queue_sel;
                        OFF_QUEUE_MAX:  n_rd_data = 32'(QUEUE_SIZE_MAX);
                        OFF_QUEUE_NUM:  n_rd_data = 32'(q_cur.size);
                        OFF_QUEUE_RDY:  n_rd_data = 32'(q_cur.ready);
                        OFF_INT_STATUS: n_rd_data = r_int_bits;
                        OFF_STATUS:     n_rd_data = r_status;
                        OFF_DESC_LO:    n_rd_data = q_cur.desc[31:0];
                        OFF_DESC_HI:    n_rd_data = q_cur.desc[63:32];
                        OFF_AVAIL_LO:   n_rd_data = q_cur.avail[31:0];
                        OFF_AVAIL_HI:   n_rd_data = q_cur.avail[63:32];
                        OFF_USED_LO:    n_rd_data = q_cur.used[31:0];
                        OFF_USED_HI:    n_rd_data = q_cur.used[63:32];
                        OFF_GENERATION: n_rd_data = '0;
                        default:        n_handled = 1'b0;
                    endcase
                end
            end
            OP_WRITE: begin
                if (r_off >= CFG_START) begin
                    cfg_we = r_cfg_hit;
                end else begin
                    unique case (r_off[7:0])
                        OFF_STATUS: begin
                            if (d == '0) begin
                                clear_all   = 1'b1;
                                n_status    = '0;
                                n_queue_sel = '0;
                                n_feat_sel  = '0;
                                n_int_bits  = '0;
                                n_irq       = 1'b0;
                            end else begin
                                n_status = d;
                            end
                        end
                        OFF_INT_ACK: begin
                            n_int_bits = r_int_bits & ~d;
                            if (n_int_bits == '0) begin
                                n_irq = 1'b0;
                            end
                        end
                        OFF_FEAT_SEL:  n_feat_sel  = d;
                        OFF_QUEUE_SEL: n_queue_sel = d;
                        OFF_QUEUE_NUM: begin
                            // power of two, non-zero, within the maximum
                            if (d != '0 && (d & (d - 32'd1)) == '0
                                    && d <= 32'(QUEUE_SIZE_MAX)) begin
                                q_new.size = d[15:0];
                                q_we       = qok;
                            end
                        end
                        OFF_QUEUE_RDY: begin
                            q_new.ready = d[0];
                            q_we        = qok;
                        end
                        OFF_DESC_LO: begin
                            q_new.desc[31:0] = d;
                            q_we             = qok;
                        end
                        OFF_DESC_HI: begin
                            q_new.desc[63:32] = d;
                            q_we              = qok;
                        end
                        OFF_AVAIL_LO: begin
                            q_new.avail[31:0] = d;
                            q_we              = qok;
                        end
                        OFF_AVAIL_HI: begin
                            q_new.avail[63:32] = d;
                            q_we               = qok;
                        end
                        OFF_USED_LO: begin
                            q_new.used[31:0] = d;
                            q_we             = qok;
                        end
                        OFF_USED_HI: begin
                            q_new.used[63:32] = d;
                            q_we              = qok;
                        end
                        OFF_NOTIFY: begin
                            if (d < 32'(NUM_QUEUES)) begin
                                ntf_inc   = 1'b1;
                                n_ntf_vld = 1'b1;
                                n_ntf_q   = d[1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_CFG_READ: begin
                if (r_cfg_hit) begin
                    n_rd_data = 32'(cfg_word >> {r_off[1:0], 3'b000}) & 32'h0000_00ff;
                    n_handled = 1'b1;
                end
            end
            OP_EVENT: begin
                n_int_bits = r_int_bits | 32'd1;
                n_irq      = 1'b1;
            end
            default: ;
        endcase
        // gate the memory writes to the completing cycle
        q_we   = q_we && complete;
        cfg_we = cfg_we && complete;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_device    <= '0;
            r_vendor    <= '0;
            r_feat_low  <= '0;
            r_status    <= '0;
            r_queue_sel <= '0;
            r_feat_sel  <= '0;
            r_int_bits  <= '0;
            r_irq       <= 1'b0;
            r_q_vld     <= '0;
            r_cfg_vld   <= '0;
            r_busy      <= 1'b0;
            r_out_vld   <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_notify_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_BASE:     r_base     <= i_cfg.data;
                    CFG_DEVICE:   r_device   <= i_cfg.data;
                    CFG_VENDOR:   r_vendor   <= i_cfg.data;
                    CFG_FEAT_LOW: r_feat_low <= i_cfg.data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_busy <= 1'b1;
            end
            // result register: a completing access refills it as it drains
            if (complete || (o_rsp.valid && o_rsp.ready)) begin
                r_out_vld <= complete;
            end
            if (complete) begin
                r_busy      <= 1'b0;
                r_status    <= n_status;
                r_queue_sel <= n_queue_sel;
                r_feat_sel  <= n_feat_sel;
                r_int_bits  <= n_int_bits;
                r_irq       <= n_irq;
                if (cfg_we) begin
                    r_cfg_vld[r_cfg_idx] <= 1'b1;
                end
                if (clear_all) begin
                    r_q_vld <= '0;
                    for (int i = 0; i < NUM_QUEUES; i++) begin
                        r_notify_cnt[i] <= '0;
                    end
                end
                if (q_we) begin
                    r_q_vld[qi] <= 1'b1;
                end
                if (ntf_inc) begin
                    r_notify_cnt[d[Q_AW-1:0]] <= r_notify_cnt[d[Q_AW-1:0]] + 32'd1;
                end
            end
        end
    end

    // Payload of the access in flight and of the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_req.op;
            r_off     <= in_off;
            r_data    <= i_req.write_data;
            r_cfg_hit <= in_cfg_hit;
            r_cfg_idx <= in_cfg_idx;
        end
        if (complete) begin
            r_rd_data <= n_rd_data;
            r_handled <= n_handled;
            r_irq_lvl <= n_irq;
            r_ntf_vld <= n_ntf_vld;
            r_ntf_q   <= n_ntf_q;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.read_data    = r_rd_data;
    assign o_rsp.handled      = r_handled;
    assign o_rsp.irq_level    = r_irq_lvl;
    assign o_rsp.notify_valid = r_ntf_vld;
    assign o_rsp.notify_queue = r_ntf_q;

    // Checks
    a_irq_matches_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == (r_int_bits != '0))
        else $error("irq level disagrees with interrupt status");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("access accepted but not in flight");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_busy))
        else $error("result appeared without an access in flight");

    a_notify_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.notify_valid) |-> (!o_rsp.handled && o_rsp.read_data == '0))
        else $error("notify flagged on a read result");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && clear_all) |=> (!r_irq && r_q_vld == '0 && r_queue_sel == '0))
        else $error("status reset left transport state behind");
endmodule

// ===== sv/vmr_ram.sv =====
module vmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== tb/virtio_mmio_register_file_test.sv =====
module virtio_mmio_register_file_test;
    import vmr_pkg::*;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 260;
    localparam int SETTLE      = 4;
    localparam int PRINT_MAX   = 40;

    typedef struct packed {
        logic [31:0] read_data;
        logic        handled;
        logic        irq_level;
        logic        notify_valid;
        logic [1:0]  notify_queue;
    } t_result;

    // Per transfer note from the sender: a fixed answer overrides the prediction
    typedef struct {
        bit      fixed;
        t_result val;
    } t_hint;

    typedef struct {
        t_op         op;
        logic [31:0] off;
        logic [31:0] data;
        bit          fixed;
        t_result     want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vmr_req_if req_ch ();
    vmr_rsp_if rsp_ch ();
    vmr_cfg_if cfg_ch ();

    virtio_mmio_register_file dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the register file
    logic [31:0] sh_base, sh_devid, sh_vendid, sh_feat_lo;
    logic [31:0] sh_status, sh_qsel, sh_fsel, sh_isr;
    logic        sh_irq;
    logic        sh_qrdy   [NUM_QUEUES];
    logic [15:0] sh_qsize  [NUM_QUEUES];
    logic [63:0] sh_desc   [NUM_QUEUES];
    logic [63:0] sh_avail  [NUM_QUEUES];
    logic [63:0] sh_used   [NUM_QUEUES];
    logic [31:0] sh_kicks  [NUM_QUEUES];
    logic [31:0] sh_cfgmem [CONFIG_WORDS];

    t_result     pending_rsp [$];
    t_hint       sent_hint [$];
    t_row        dir_rows [$];
    int          errors      = 0;
    int          cycles      = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    int          hold_asked  = 0;
    int          hold_served = 0;
    logic [31:0] win_base    = '0;

    // Status write of zero: everything but config space goes back to reset
    function automatic void wipe_transport();
        sh_status = '0;
        sh_qsel   = '0;
        sh_fsel   = '0;
        sh_isr    = '0;
        sh_irq    = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            sh_qrdy[q]  = 1'b0;
            sh_qsize[q] = '0;
            sh_desc[q]  = '0;
            sh_avail[q] = '0;
            sh_used[q]  = '0;
            sh_kicks[q] = '0;
        end
    endfunction

    initial begin
        sh_base    = '0;
        sh_devid   = '0;
        sh_vendid  = '0;
        sh_feat_lo = '0;
        wipe_transport();
        for (int w = 0; w < CONFIG_WORDS; w++) sh_cfgmem[w] = '0;
    end

    // Works out the result of one access and updates the shadow state
    function automatic t_result predict_access(t_op op, logic [31:0] addr, logic [31:0] d);
        t_result     r;
        logic [31:0] off;
        logic [31:0] w;
        bit          qok;
        int          q;
        r   = '0;
        off = addr - sh_base;
        qok = sh_qsel < NUM_QUEUES;
        q   = qok ? int'(sh_qsel) : 0;
        case (op)
            OP_READ: begin
                if (off >= CFG_START) begin
                    w = (off - CFG_START) >> 2;
                    if (w < CONFIG_WORDS) begin
                        r.read_data = sh_cfgmem[w];
                        r.handled   = 1'b1;
                    end
                end else begin
                    r.handled = 1'b1;
                    case (off[7:0])
                        OFF_MAGIC:      r.read_data = MAGIC_WORD;
                        OFF_VERSION:    r.read_data = VERSION;
                        OFF_DEVICE_ID:  r.read_data = sh_devid;
                        OFF_VENDOR_ID:  r.read_data = sh_vendid;
                        OFF_FEATURES:   r.read_data = (sh_fsel == 0) ? sh_feat_lo :
                                                      (sh_fsel == 1) ? 32'd1 : 32'd0;
                        OFF_FEAT_SEL:   r.read_data = sh_fsel;
                        OFF_QUEUE_SEL:  r.read_data = sh_qsel;
                        OFF_QUEUE_MAX:  r.read_data = QUEUE_SIZE_MAX;
                        OFF_QUEUE_NUM:  if (qok) r.read_data = {16'd0, sh_qsize[q]};
                        OFF_QUEUE_RDY:  if (qok) r.read_data = {31'd0, sh_qrdy[q]};
                        OFF_INT_STATUS: r.read_data = sh_isr;
                        OFF_STATUS:     r.read_data = sh_status;
                        OFF_DESC_LO:    if (qok) r.read_data = sh_desc[q][31:0];
                        OFF_DESC_HI:    if (qok) r.read_data = sh_desc[q][63:32];
                        OFF_AVAIL_LO:   if (qok) r.read_data = sh_avail[q][31:0];
                        OFF_AVAIL_HI:   if (qok) r.read_data = sh_avail[q][63:32];
                        OFF_USED_LO:    if (qok) r.read_data = sh_used[q][31:0];
                        OFF_USED_HI:    if (qok) r.read_data = sh_used[q][63:32];
                        OFF_GENERATION: r.read_data = '0;
                        default:        r.handled = 1'b0;
                    endcase
                end
            end
            OP_WRITE: begin
                if (off >= CFG_START) begin
                    w = (off - CFG_START) >> 2;
                    if (w < CONFIG_WORDS) sh_cfgmem[w] = d;
                end else begin
                    case (off[7:0])
                        OFF_STATUS: begin
                            if (d == 0) wipe_transport();
                            else sh_status = d;
                        end
                        OFF_INT_ACK: begin
                            sh_isr = sh_isr & ~d;
                            if (sh_isr == 0) sh_irq = 1'b0;
                        end
                        OFF_FEAT_SEL:  sh_fsel = d;
                        OFF_QUEUE_SEL: sh_qsel = d;
                        OFF_QUEUE_NUM: begin
                            if (qok && d != 0 && (d & (d - 1)) == 0 && d <= QUEUE_SIZE_MAX)
                                sh_qsize[q] = d[15:0];
                        end
                        OFF_QUEUE_RDY: if (qok) sh_qrdy[q] = d[0];
                        OFF_DESC_LO:   if (qok) sh_desc[q][31:0]   = d;
                        OFF_DESC_HI:   if (qok) sh_desc[q][63:32]  = d;
                        OFF_AVAIL_LO:  if (qok) sh_avail[q][31:0]  = d;
                        OFF_AVAIL_HI:  if (qok) sh_avail[q][63:32] = d;
                        OFF_USED_LO:   if (qok) sh_used[q][31:0]   = d;
                        OFF_USED_HI:   if (qok) sh_used[q][63:32]  = d;
                        OFF_NOTIFY: begin
                            if (d < NUM_QUEUES) begin
                                sh_kicks[d] = sh_kicks[d] + 1;
                                r.notify_valid = 1'b1;
                                r.notify_queue = d[1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_CFG_READ: begin
                if (off >= CFG_START) begin
                    w = (off - CFG_START) >> 2;
                    if (w < CONFIG_WORDS) begin
                        r.read_data = (sh_cfgmem[w] >> (8 * off[1:0])) & 32'hff;
                        r.handled   = 1'b1;
                    end
                end
            end
            default: begin
                sh_isr = sh_isr | 32'd1;
                sh_irq = 1'b1;
            end
        endcase
        r.irq_level = sh_irq;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= PRINT_MAX)
            $display("cycle %0d: %s mismatch, got %h want %h", cycles, what, got, want);
    endtask

    // Monitor: checks result transfers, tracks config writes, predicts on request transfers
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_hint   h;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.read_data    = rsp_ch.read_data;
                got.handled      = rsp_ch.handled;
                got.irq_level    = rsp_ch.irq_level;
                got.notify_valid = rsp_ch.notify_valid;
                got.notify_queue = rsp_ch.notify_queue;
                if (pending_rsp.size() == 0) begin
                    report("unrequested result", got.read_data, '0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (got.read_data !== want.read_data)
                        report("read_data", got.read_data, want.read_data);
                    if (got.handled !== want.handled)
                        report("handled", 32'(got.handled), 32'(want.handled));
                    if (got.irq_level !== want.irq_level)
                        report("irq_level", 32'(got.irq_level), 32'(want.irq_level));
                    if (got.notify_valid !== want.notify_valid)
                        report("notify_valid", 32'(got.notify_valid), 32'(want.notify_valid));
                    if (got.notify_queue !== want.notify_queue)
                        report("notify_queue", 32'(got.notify_queue), 32'(want.notify_queue));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_BASE:     sh_base    = cfg_ch.data;
                    CFG_DEVICE:   sh_devid   = cfg_ch.data;
                    CFG_VENDOR:   sh_vendid  = cfg_ch.data;
                    CFG_FEAT_LOW: sh_feat_lo = cfg_ch.data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                want = predict_access(t_op'(req_ch.op), req_ch.bus_address, req_ch.write_data);
                if (sent_hint.size() != 0) begin
                    h = sent_hint.pop_front();
                    if (h.fixed) want = h.val;
                end
                pending_rsp.push_back(want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : rsp_taker
        int wait_n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            wait_n = rx_steady ? 0 : $urandom_range(0, 17);
            if (hold_asked != hold_served) begin
                wait_n += HOLD_CYCLES;
                hold_served++;
            end
            if (wait_n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // One request transfer; valid stays high across back-to-back items
    task automatic send_access(input t_op op, input logic [31:0] addr, input logic [31:0] data,
                               input bit fixed, input t_result want);
        int    gap;
        t_hint h;
        h.fixed = fixed;
        h.val   = want;
        sent_hint.push_back(h);
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.bus_address <= addr;
        req_ch.write_data  <= data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic cfg_transfer(input t_cfg_idx idx, input logic [31:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_settings(input logic [31:0] base, input logic [31:0] devid,
                                  input logic [31:0] vendid, input logic [31:0] feat);
        cfg_ch.valid <= 1'b1;
        cfg_transfer(CFG_BASE, base);
        cfg_transfer(CFG_DEVICE, devid);
        cfg_transfer(CFG_VENDOR, vendid);
        cfg_transfer(CFG_FEAT_LOW, feat);
        cfg_ch.valid <= 1'b0;
        win_base = base;
    endtask

    // Wait for every outstanding result, then let the pipeline go quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0 || sent_hint.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_result res(logic [31:0] rd, logic hd, logic irq, logic nv,
                                    logic [1:0] nq);
        t_result r;
        r.read_data    = rd;
        r.handled      = hd;
        r.irq_level    = irq;
        r.notify_valid = nv;
        r.notify_queue = nq;
        return r;
    endfunction

    function automatic void add_row(t_op op, logic [31:0] off, logic [31:0] data, bit fixed,
                                    t_result want);
        t_row r;
        r.op    = op;
        r.off   = off;
        r.data  = data;
        r.fixed = fixed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_reg_offset();
        case ($urandom_range(0, 23))
            0:       return OFF_MAGIC;
            1:       return OFF_VERSION;
            2:       return OFF_DEVICE_ID;
            3:       return OFF_VENDOR_ID;
            4:       return OFF_FEATURES;
            5:       return OFF_FEAT_SEL;
            6:       return OFF_QUEUE_SEL;
            7:       return OFF_QUEUE_MAX;
            8:       return OFF_QUEUE_NUM;
            9:       return OFF_QUEUE_RDY;
            10:      return OFF_NOTIFY;
            11:      return OFF_INT_STATUS;
            12:      return OFF_INT_ACK;
            13:      return OFF_STATUS;
            14:      return OFF_DESC_LO;
            15:      return OFF_DESC_HI;
            16:      return OFF_AVAIL_LO;
            17:      return OFF_AVAIL_HI;
            18:      return OFF_USED_LO;
            19:      return OFF_USED_HI;
            20:      return OFF_GENERATION;
            21:      return 8'h18;
            22:      return 8'h3c;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly sensible values for each register, sometimes anything
    function automatic logic [31:0] shape_data(logic [7:0] reg_off);
        logic [31:0] d;
        d = $urandom;
        if ($urandom_range(0, 4) != 0) begin
            case (reg_off)
                OFF_QUEUE_SEL, OFF_NOTIFY: d = $urandom_range(0, 5);
                OFF_FEAT_SEL:              d = $urandom_range(0, 2);
                OFF_QUEUE_NUM:             d = 32'd1 << $urandom_range(0, 9);
                OFF_QUEUE_RDY:             d = $urandom_range(0, 1);
                OFF_STATUS:                if ($urandom_range(0, 2) == 0) d = '0;
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic void draw_access(output t_op op, output logic [31:0] off,
                                        output logic [31:0] data);
        int         sel;
        logic [7:0] ro;
        ro   = '0;
        data = $urandom;
        sel  = $urandom_range(0, 99);
        // noise: any access anywhere
        if (sel < 8) begin
            op  = t_op'($urandom_range(0, 3));
            off = $urandom;
            return;
        end
        sel = $urandom_range(0, 99);
        op  = (sel < 38) ? OP_READ : (sel < 80) ? OP_WRITE : (sel < 93) ? OP_CFG_READ : OP_EVENT;
        sel = $urandom_range(0, 99);
        if (op == OP_CFG_READ) begin
            if (sel < 80)      off = CFG_START + $urandom_range(0, 255);
            else if (sel < 90) off = CFG_START + 256 + $urandom_range(0, 4095);
            else               off = $urandom_range(0, 255);
        end else if (sel < 72) begin
            ro  = pick_reg_offset();
            off = {24'd0, ro};
        end else if (sel < 92) begin
            off = CFG_START + 4 * $urandom_range(0, CONFIG_WORDS - 1);
            if ($urandom_range(0, 7) == 0) off = off + $urandom_range(0, 3);
        end else begin
            off = CFG_START + 256 + $urandom_range(0, 65535);
        end
        if (op == OP_WRITE && off < CFG_START) data = shape_data(ro);
    endfunction

    initial begin : stimulus
        t_op         op;
        logic [31:0] off;
        logic [31:0] data;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_READ;
        req_ch.bus_address = '0;
        req_ch.write_data  = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_BASE;
        cfg_ch.data        = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, window at address zero
        apply_settings(32'h0, 32'hffff_ffff, 32'h0, 32'ha5a5_5a5a);
        add_row(OP_READ, OFF_MAGIC, 0, 1, res(MAGIC_WORD, 1, 0, 0, 0));
        add_row(OP_READ, OFF_DEVICE_ID, 0, 1, res(32'hffff_ffff, 1, 0, 0, 0));
        add_row(OP_READ, OFF_FEATURES, 0, 1, res(32'ha5a5_5a5a, 1, 0, 0, 0));
        add_row(OP_WRITE, OFF_FEAT_SEL, 1, 1, res(0, 0, 0, 0, 0));
        add_row(OP_READ, OFF_FEATURES, 0, 1, res(1, 1, 0, 0, 0));
        add_row(OP_WRITE, OFF_FEAT_SEL, 32'hffff_ffff, 1, res(0, 0, 0, 0, 0));
        add_row(OP_READ, OFF_FEATURES, 0, 1, res(0, 1, 0, 0, 0));
        // unknown offset
        add_row(OP_READ, 8'h18, 0, 1, res(0, 0, 0, 0, 0));
        add_row(OP_READ, OFF_QUEUE_MAX, 0, 1, res(QUEUE_SIZE_MAX, 1, 0, 0, 0));
        // queue size: largest legal, too big, not a power of two
        add_row(OP_WRITE, OFF_QUEUE_NUM, QUEUE_SIZE_MAX, 0, '0);
        add_row(OP_WRITE, OFF_QUEUE_NUM, 2 * QUEUE_SIZE_MAX, 0, '0);
        add_row(OP_WRITE, OFF_QUEUE_NUM, 3, 0, '0);
        add_row(OP_READ, OFF_QUEUE_NUM, 0, 1, res(QUEUE_SIZE_MAX, 1, 0, 0, 0));
        // out-of-range queue select
        add_row(OP_WRITE, OFF_QUEUE_SEL, 32'hffff_ffff, 0, '0);
        add_row(OP_READ, OFF_QUEUE_NUM, 0, 1, res(0, 1, 0, 0, 0));
        add_row(OP_WRITE, OFF_DESC_HI, 32'hffff_ffff, 0, '0);
        add_row(OP_WRITE, OFF_QUEUE_SEL, 0, 0, '0);
        add_row(OP_READ, OFF_DESC_HI, 0, 1, res(0, 1, 0, 0, 0));
        // completion event and ack
        add_row(OP_EVENT, 0, 0, 1, res(0, 0, 1, 0, 0));
        add_row(OP_READ, OFF_INT_STATUS, 0, 1, res(1, 1, 1, 0, 0));
        add_row(OP_WRITE, OFF_INT_ACK, 1, 1, res(0, 0, 0, 0, 0));
        // notify, last queue and one past
        add_row(OP_WRITE, OFF_NOTIFY, NUM_QUEUES - 1, 1, res(0, 0, 0, 1, 2'(NUM_QUEUES - 1)));
        add_row(OP_WRITE, OFF_NOTIFY, NUM_QUEUES, 1, res(0, 0, 0, 0, 0));
        // config window: byte order, below window, beyond window
        add_row(OP_WRITE, CFG_START, 32'hff00_1234, 0, '0);
        add_row(OP_CFG_READ, CFG_START + 3, 0, 1, res(32'hff, 1, 0, 0, 0));
        add_row(OP_CFG_READ, OFF_GENERATION, 0, 1, res(0, 0, 0, 0, 0));
        add_row(OP_READ, CFG_START + 4 * CONFIG_WORDS, 0, 1, res(0, 0, 0, 0, 0));
        // status zero clears irq too
        add_row(OP_EVENT, 0, 0, 1, res(0, 0, 1, 0, 0));
        add_row(OP_WRITE, OFF_STATUS, 0, 1, res(0, 0, 0, 0, 0));
        add_row(OP_READ, OFF_STATUS, 0, 1, res(0, 1, 0, 0, 0));
        foreach (dir_rows[k])
            send_access(dir_rows[k].op, win_base + dir_rows[k].off, dir_rows[k].data,
                        dir_rows[k].fixed, dir_rows[k].want);
        settle();

        // Random phases, each under its own register settings
        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1:       apply_settings(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
                2:       apply_settings($urandom, $urandom, $urandom, 32'h0);
                3:       apply_settings(32'hffff_ff00, $urandom, $urandom, $urandom);
                4:       apply_settings($urandom, 32'hffff_ffff, 32'h0, $urandom);
                default: apply_settings(32'h0, $urandom, $urandom, $urandom);
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                // long result hold-off while requests keep coming
                if (p == 2 && i == 60) begin
                    hold_asked++;
                    tx_steady = 1'b1;
                end
                draw_access(op, off, data);
                send_access(op, win_base + off, data, 1'b0, '0);
            end
            settle();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/vmr_pkg.sv
sv/vmr_req_if.sv
sv/vmr_rsp_if.sv
sv/vmr_cfg_if.sv
sv/vmr_ram.sv
sv/virtio_mmio_register_file.sv
tb/virtio_mmio_register_file_test.sv
